// File: hdl/rat_pkg.sv
// rat_pkg: shared widths, register indexes and stage types for the rssi
// anomaly tracker. No dependencies; every other file in hdl imports it.
package rat_pkg;

	// field widths
	localparam int SAMPLE_W  = 8;
	localparam int FRAC_W    = 16;
	localparam int AVG_W     = 24;
	localparam int DEV_W     = 23;
	localparam int MIN_DEV_W = 7;
	localparam int BAND_W    = 5;
	localparam int CFG_W     = 7;
	localparam int CFG_IDX_W = 1;

	// working width of the constant dividers, covers |sample - average|
	localparam int DIV_W = 25;

	// limits of the stored values
	localparam logic signed [AVG_W-1:0] AVG_MAX = 24'sh7FFFFF;
	localparam logic signed [AVG_W-1:0] AVG_MIN = 24'sh800000;
	localparam logic [DEV_W-1:0]        DEV_MAX = 23'h7FFFFF;

	// register reset values
	localparam logic [MIN_DEV_W-1:0] MIN_DEV_RST = 7'd5;
	localparam logic [BAND_W-1:0]    BAND_RST    = 5'd6;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MIN_DEVIATION = 1'b0,
		CFG_BAND_FACTOR   = 1'b1
	} rat_cfg_idx_t;

	// live configuration seen by the deviation stage
	typedef struct packed {
		logic [MIN_DEV_W-1:0] min_deviation;
		logic [BAND_W-1:0]    band_factor_quarters;
	} rat_cfg_t;

	// sample after the input register
	typedef struct packed {
		logic signed [AVG_W-1:0] sq;
		logic signed [AVG_W-1:0] sq_div;
	} rat_s1_t;

	// request after the average stage
	typedef struct packed {
		logic signed [AVG_W-1:0] sq;
		logic signed [AVG_W-1:0] avg_old;
		logic signed [AVG_W-1:0] avg_new;
	} rat_s2_t;

endpackage

// File: hdl/rssi_anomaly_tracker_top.sv
// rssi_anomaly_tracker_top: input register, average and deviation stages,
// handshake control and configuration registers. Depends on rat_pkg,
// rat_div_const, rat_avg_stage and rat_dev_stage.
//
// Takes one signed dBm sample per request and returns one result per sample:
// whether the sample lay outside average +/- band (checked against the values
// stored before it), then the updated Q.16 average and deviation. The block
// accepts a sample every cycle unless in_stall holds it off, and passes each
// sample through an input register that also holds sample/N, an average stage
// whose running-average update closes within the stage, and a deviation stage
// that does the band check and closes the running-deviation update within the
// stage. Each of those two recurrences costs one constant-reciprocal multiply
// per cycle, which sets the clock. A stalled result does not block earlier
// stages from filling.
module rssi_anomaly_tracker_top import rat_pkg::*; #(
	parameter int SMOOTHING_SAMPLES = 100
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic signed [SAMPLE_W-1:0] rssi_sample,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic                       outside_band,
	output logic signed [AVG_W-1:0]    average_level,
	output logic [DEV_W-1:0]           deviation_level,
	input  logic                       cfg_we,
	input  logic [CFG_IDX_W-1:0]       cfg_index,
	input  logic [CFG_W-1:0]           cfg_data
);

	logic                    v1_q;
	logic                    v2_q;
	logic                    v3_q;
	logic                    adv1;
	logic                    adv2;
	logic                    adv3;
	logic                    move1;
	logic                    move2;
	logic                    in_fire;
	logic                    out_fire;
	rat_cfg_t                cfg_q;
	logic signed [DIV_W-1:0] sq_ext;
	logic [DIV_W-1:0]        sq_mag;
	logic [DIV_W-1:0]        sq_quo;
	rat_s1_t                 s1_s1;
	rat_s2_t                 s2;

	// pipeline advance: a stage takes a request when empty or when it drains
	always_comb begin
		adv3     = !v3_q || !out_stall;
		move2    = v2_q && adv3;
		adv2     = !v2_q || adv3;
		move1    = v1_q && adv2;
		adv1     = !v1_q || adv2;
		in_stall = !adv1;
		in_fire  = in_valid && adv1;
		out_fire = v3_q && !out_stall;
	end

	// stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
			v3_q <= 1'b0;
		end else begin
			v1_q <= in_fire || (v1_q && !move1);
			v2_q <= move1 || (v2_q && !move2);
			v3_q <= move2 || (v3_q && !out_fire);
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_deviation        <= MIN_DEV_RST;
			cfg_q.band_factor_quarters <= BAND_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_MIN_DEVIATION: cfg_q.min_deviation        <= cfg_data[MIN_DEV_W-1:0];
				CFG_BAND_FACTOR:   cfg_q.band_factor_quarters <= cfg_data[BAND_W-1:0];
				default: ;
			endcase
		end
	end

	// sample scaled to Q.16 and its magnitude for sample/N
	always_comb begin
		sq_ext = DIV_W'(signed'({rssi_sample, {FRAC_W{1'b0}}}));
		sq_mag = sq_ext[DIV_W-1] ? unsigned'(-sq_ext) : unsigned'(sq_ext);
	end

	rat_div_const #(
		.DIVISOR (SMOOTHING_SAMPLES),
		.IN_W    (DIV_W)
	) u_sq_div (
		.dividend (sq_mag),
		.quotient (sq_quo)
	);

	// input register
	always_ff @(posedge clk) begin
		if (in_fire) begin
			s1_s1.sq     <= AVG_W'(sq_ext);
			s1_s1.sq_div <= sq_ext[DIV_W-1] ? AVG_W'(-signed'(sq_quo))
			                                : AVG_W'(signed'(sq_quo));
		end
	end

	rat_avg_stage #(
		.SMOOTHING_SAMPLES (SMOOTHING_SAMPLES)
	) u_avg_stage (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (move1),
		.s1     (s1_s1),
		.s2     (s2)
	);

	rat_dev_stage #(
		.SMOOTHING_SAMPLES (SMOOTHING_SAMPLES)
	) u_dev_stage (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (move2),
		.s2         (s2),
		.cfg        (cfg_q),
		.outside_s3 (outside_band),
		.avg_s3     (average_level),
		.dev_s3     (deviation_level)
	);

	assign out_valid = v3_q;

	// input is held off only when every stage is full and the output stalls
	assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (v1_q && v2_q && v3_q && out_stall))
		else $error("input stalled while the pipeline had room");

	// a request leaving the average stage shows up as a result next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		move2 |=> out_valid)
		else $error("result missing after deviation stage load");

	// a taken result with nothing behind it leaves the output empty
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && !v2_q) |=> !out_valid)
		else $error("result repeated after it was taken");

endmodule

// File: hdl/rat_div_const.sv
// rat_div_const: unsigned division by an elaboration-time constant through
// an exact reciprocal multiply. Uses rat_pkg only for the import convention.
module rat_div_const import rat_pkg::*; #(
	parameter int DIVISOR = 100,
	parameter int IN_W    = 25
) (
	input  logic [IN_W-1:0] dividend,
	output logic [IN_W-1:0] quotient
);

	// multiplier ceil(2^SHIFT / DIVISOR) is exact for every dividend below 2^IN_W
	localparam int SHIFT  = IN_W + $clog2(DIVISOR);
	localparam int MULT_W = IN_W + 2;
	localparam int PROD_W = SHIFT + IN_W + 2;
	localparam logic [63:0] MULT_FULL =
		((64'd1 << SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
	localparam logic [MULT_W-1:0] MULT = MULT_FULL[MULT_W-1:0];

	logic [PROD_W-1:0] prod;

	// reciprocal multiply and shift
	always_comb begin
		prod     = PROD_W'(dividend) * PROD_W'(MULT);
		quotient = prod[SHIFT +: IN_W];
	end

endmodule

// File: hdl/rat_avg_stage.sv
// rat_avg_stage: running average register and its update, plus the
// stage-two pipeline register. Depends on rat_pkg and rat_div_const.
module rat_avg_stage import rat_pkg::*; #(
	parameter int SMOOTHING_SAMPLES = 100
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    load,
	input  rat_s1_t s1,
	output rat_s2_t s2
);

	localparam int SUM_W = DIV_W + 2;

	logic signed [AVG_W-1:0] avg_q;
	logic signed [AVG_W-1:0] seed;
	logic signed [DIV_W-1:0] seed_ext;
	logic [DIV_W-1:0]        seed_mag;
	logic [DIV_W-1:0]        seed_quo;
	logic signed [DIV_W-1:0] seed_div;
	logic signed [SUM_W-1:0] sum;
	logic signed [AVG_W-1:0] avg_new;
	rat_s2_t                 s2_s2;

	// magnitude of the seeded average for the divider
	always_comb begin
		seed     = (avg_q == '0) ? s1.sq : avg_q;
		seed_ext = DIV_W'(seed);
		seed_mag = seed_ext[DIV_W-1] ? unsigned'(-seed_ext) : unsigned'(seed_ext);
	end

	rat_div_const #(
		.DIVISOR (SMOOTHING_SAMPLES),
		.IN_W    (DIV_W)
	) u_avg_div (
		.dividend (seed_mag),
		.quotient (seed_quo)
	);

	// avg - avg/N + sample/N, truncating toward zero, then clamp
	always_comb begin
		seed_div = seed_ext[DIV_W-1] ? -signed'(seed_quo) : signed'(seed_quo);
		sum      = SUM_W'(seed_ext) - SUM_W'(seed_div) + SUM_W'(s1.sq_div);
		if (sum > SUM_W'(AVG_MAX)) begin
			avg_new = AVG_MAX;
		end else if (sum < SUM_W'(AVG_MIN)) begin
			avg_new = AVG_MIN;
		end else begin
			avg_new = AVG_W'(sum);
		end
	end

	// running average, zero means unset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			avg_q <= '0;
		end else if (load) begin
			avg_q <= avg_new;
		end
	end

	// stage-two payload
	always_ff @(posedge clk) begin
		if (load) begin
			s2_s2.sq      <= s1.sq;
			s2_s2.avg_old <= avg_q;
			s2_s2.avg_new <= avg_new;
		end
	end

	assign s2 = s2_s2;

endmodule

// File: hdl/rat_dev_stage.sv
// rat_dev_stage: band check against the stored values, running deviation
// register and its update, and the result register. Depends on rat_pkg and
// rat_div_const.
module rat_dev_stage import rat_pkg::*; #(
	parameter int SMOOTHING_SAMPLES = 100
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    load,
	input  rat_s2_t                 s2,
	input  rat_cfg_t                cfg,
	output logic                    outside_s3,
	output logic signed [AVG_W-1:0] avg_s3,
	output logic [DEV_W-1:0]        dev_s3
);

	localparam int PROD_W = DEV_W + BAND_W;
	localparam int CMP_W  = PROD_W + 1;

	logic [DEV_W-1:0]        dev_q;
	logic [PROD_W-1:0]       band_prod;
	logic signed [CMP_W-1:0] band_w;
	logic signed [CMP_W-1:0] avg_w;
	logic signed [CMP_W-1:0] sq_w;
	logic signed [CMP_W-1:0] upper;
	logic signed [CMP_W-1:0] lower;
	logic                    outside;
	logic signed [DIV_W-1:0] diff_s;
	logic [DIV_W-1:0]        diff_mag;
	logic [DIV_W-1:0]        diff_quo;
	logic [DEV_W-1:0]        floor_q;
	logic [DEV_W-1:0]        dev_seed;
	logic [DIV_W-1:0]        dev_seed_ext;
	logic [DIV_W-1:0]        dev_quo;
	logic [DIV_W:0]          dev_sum;
	logic [DEV_W-1:0]        dev_new;

	// band check with the values stored before this sample
	always_comb begin
		band_prod = PROD_W'(dev_q) * PROD_W'(cfg.band_factor_quarters);
		band_w    = signed'(CMP_W'(band_prod >> 2));
		avg_w     = CMP_W'(s2.avg_old);
		sq_w      = CMP_W'(s2.sq);
		upper     = avg_w + band_w;
		lower     = avg_w - band_w;
		outside   = (sq_w > upper) || (sq_w < lower);
	end

	// distance from the new average and the seeded deviation
	always_comb begin
		diff_s       = DIV_W'(s2.sq) - DIV_W'(s2.avg_new);
		diff_mag     = diff_s[DIV_W-1] ? unsigned'(-diff_s) : unsigned'(diff_s);
		floor_q      = {cfg.min_deviation, {FRAC_W{1'b0}}};
		dev_seed     = (dev_q == '0) ? floor_q : dev_q;
		dev_seed_ext = DIV_W'(dev_seed);
	end

	rat_div_const #(
		.DIVISOR (SMOOTHING_SAMPLES),
		.IN_W    (DIV_W)
	) u_diff_div (
		.dividend (diff_mag),
		.quotient (diff_quo)
	);

	rat_div_const #(
		.DIVISOR (SMOOTHING_SAMPLES),
		.IN_W    (DIV_W)
	) u_dev_div (
		.dividend (dev_seed_ext),
		.quotient (dev_quo)
	);

	// move toward the distance only when it clears the floor, then saturate
	always_comb begin
		dev_sum = (DIV_W+1)'(dev_seed_ext) - (DIV_W+1)'(dev_quo) + (DIV_W+1)'(diff_quo);
		if (diff_mag > DIV_W'(floor_q)) begin
			if (dev_sum > (DIV_W+1)'(DEV_MAX)) begin
				dev_new = DEV_MAX;
			end else begin
				dev_new = dev_sum[DEV_W-1:0];
			end
		end else begin
			dev_new = dev_seed;
		end
	end

	// running deviation, zero means unset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev_q <= '0;
		end else if (load) begin
			dev_q <= dev_new;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (load) begin
			outside_s3 <= outside;
			avg_s3     <= s2.avg_new;
			dev_s3     <= dev_new;
		end
	end

endmodule
